// ----- design/tcw_pkg.sv -----
// Package for the text console writer: screen geometry, item types, codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TAB_STEP = 5;
    localparam int QDEPTH = 2;

    localparam logic [2:0] ADDR_BACK = 3'd0;
    localparam logic [2:0] ADDR_FORE = 3'd4;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SETC  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        OP_PRINT, OP_LF, OP_CR, OP_BS, OP_TAB, OP_CLEAR, OP_SETC, OP_READ
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_EXEC, ST_BSRD, ST_FILL, ST_RDWAIT, ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       char_code;
        logic [7:0]       clear_attr;
        logic [COL_W-1:0] target_col;
        logic [ROW_W-1:0] target_row;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       char_code;
        logic [7:0]       clear_attr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cmd_t;
endpackage
`default_nettype wire

// ----- design/tcw_front.sv -----
// Front end: accepts request items, saturates targets, decodes the operation,
// and queues decoded commands for the back end. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire tcw_pkg::in_item_t in_item,
    output logic                  cmd_valid,
    output tcw_pkg::cmd_t         cmd,
    input  wire logic             cmd_take
);
    import tcw_pkg::*;

    cmd_t q_reg [QDEPTH];
    logic [$clog2(QDEPTH):0] cnt_reg, cnt_next;
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    cmd_t dec;
    logic do_push, do_pop;

    always_comb
    begin
        dec.char_code  = in_item.char_code;
        dec.clear_attr = in_item.clear_attr;
        dec.col = (in_item.target_col > LAST_COL) ? LAST_COL : in_item.target_col;
        dec.row = (in_item.target_row > LAST_ROW) ? LAST_ROW : in_item.target_row;
        case (req_t'(in_item.req_type))
            REQ_PUT:
            begin
                case (in_item.char_code)
                    CH_LF:   dec.op = OP_LF;
                    CH_CR:   dec.op = OP_CR;
                    CH_BS:   dec.op = OP_BS;
                    CH_TAB:  dec.op = OP_TAB;
                    default: dec.op = OP_PRINT;
                endcase
            end
            REQ_CLEAR: dec.op = OP_CLEAR;
            REQ_SETC:  dec.op = OP_SETC;
            default:   dec.op = OP_READ;
        endcase
    end

    assign full      = (cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= dec;
    end
endmodule
`default_nettype wire

// ----- design/tcw_back.sv -----
// Back end: executes decoded commands against the screen memory and cursor,
// including row scroll, full clear and the reset clearing pass. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    input  wire tcw_pkg::cmd_t cmd,
    output logic              cmd_take,
    input  wire logic [3:0]   back_color,
    input  wire logic [3:0]   fore_color,
    output logic              res_valid,
    output tcw_pkg::out_item_t res,
    input  wire logic         res_take
);
    import tcw_pkg::*;

    logic [15:0] mem [CELLS];
    logic [15:0] rd_q;

    state_t state_reg, state_next;
    cmd_t   c_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] fa_reg, fa_next, fend_reg, fend_next;
    logic [15:0] fval_reg, fval_next;
    logic [7:0] rch_reg, rch_next, rat_reg, rat_next;
    logic [7:0] wattr;

    logic        we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [15:0] wdata;

    // address of a visible cell
    logic [COL_W-1:0] a_col;
    logic [ROW_W-1:0] a_row;
    logic [ROW_W:0]   phys_sum;
    logic [ROW_W-1:0] phys;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] top_base;
    logic [COL_W:0] col_p;
    logic [COL_W-1:0] bs_col;

    assign wattr = {back_color, fore_color};
    assign bs_col = (col_reg != '0) ? col_reg - 1'b1 : col_reg;

    always_comb
    begin
        phys_sum = {1'b0, top_reg} + {1'b0, a_row};
        phys = (phys_sum >= (ROW_W+1)'(SCREEN_HEIGHT))
            ? ROW_W'(phys_sum - (ROW_W+1)'(SCREEN_HEIGHT)) : phys_sum[ROW_W-1:0];
        a_addr = ADDR_W'(phys * SCREEN_WIDTH) + ADDR_W'(a_col);
        top_base = ADDR_W'(top_reg * SCREEN_WIDTH);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:   if (fa_reg == fend_reg) state_next = ST_IDLE;
            ST_IDLE:   if (cmd_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                case (c_reg.op)
                    OP_BS:    state_next = ST_BSRD;
                    OP_READ:  state_next = ST_RDWAIT;
                    OP_CLEAR: state_next = ST_FILL;
                    OP_LF:    state_next = (row_reg == LAST_ROW) ? ST_FILL : ST_DONE;
                    OP_TAB, OP_PRINT:
                        state_next = (col_p > {1'b0, LAST_COL} && row_reg == LAST_ROW)
                            ? ST_FILL : ST_DONE;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_BSRD:   state_next = ST_DONE;
            ST_RDWAIT: state_next = ST_DONE;
            ST_FILL:   if (fa_reg == fend_reg) state_next = ST_DONE;
            ST_DONE:   if (res_take) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        col_p = {1'b0, col_reg} + ((c_reg.op == OP_TAB) ? (COL_W+1)'(TAB_STEP)
                                                          : (COL_W+1)'(1));
        col_next = col_reg; row_next = row_reg; top_next = top_reg;
        fa_next = fa_reg; fend_next = fend_reg; fval_next = fval_reg;
        rch_next = rch_reg; rat_next = rat_reg;
        we = 1'b0; re = 1'b0; waddr = fa_reg; raddr = a_addr; wdata = fval_reg;
        a_col = col_reg; a_row = row_reg;
        cmd_take = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                we = 1'b1;
                fa_next = fa_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cmd_take = cmd_valid;
                rch_next = '0; rat_next = '0;
            end
            ST_EXEC:
            begin
                case (c_reg.op)
                    OP_PRINT:
                    begin
                        we = 1'b1; waddr = a_addr; wdata = {wattr, c_reg.char_code};
                    end
                    OP_BS:
                    begin
                        a_col = bs_col; re = 1'b1; col_next = bs_col;
                    end
                    OP_READ:
                    begin
                        a_col = c_reg.col; a_row = c_reg.row; re = 1'b1;
                    end
                    OP_CR: col_next = '0;
                    OP_SETC:
                    begin
                        col_next = c_reg.col; row_next = c_reg.row;
                    end
                    OP_CLEAR:
                    begin
                        fa_next = '0; fend_next = ADDR_W'(CELLS - 1);
                        fval_next = {c_reg.clear_attr, CH_SPACE};
                        col_next = '0; row_next = '0; top_next = '0;
                    end
                    default: ;
                endcase
                if (c_reg.op == OP_LF ||
                    ((c_reg.op == OP_TAB || c_reg.op == OP_PRINT) && col_p > {1'b0, LAST_COL}))
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        fa_next = top_base;
                        fend_next = top_base + ADDR_W'(SCREEN_WIDTH - 1);
                        fval_next = {wattr, 8'h00};
                        top_next = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                    end
                    else
                        row_next = row_reg + 1'b1;
                end
                else if (c_reg.op == OP_TAB || c_reg.op == OP_PRINT)
                    col_next = col_p[COL_W-1:0];
            end
            ST_BSRD:
            begin
                we = 1'b1; waddr = a_addr; wdata = {rd_q[15:8], 8'h00};
            end
            ST_RDWAIT:
            begin
                rch_next = rd_q[7:0]; rat_next = rd_q[15:8];
            end
            ST_FILL:
            begin
                we = 1'b1;
                fa_next = fa_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res = '{cell_char: rch_reg, cell_attr: rat_reg,
                   cursor_col: col_reg, cursor_row: row_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            col_reg <= '0; row_reg <= '0; top_reg <= '0;
            fa_reg <= '0; fend_reg <= ADDR_W'(CELLS - 1); fval_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next; row_reg <= row_next; top_reg <= top_next;
            fa_reg <= fa_next; fend_reg <= fend_next; fval_reg <= fval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rch_reg <= rch_next;
        rat_reg <= rat_next;
        if (cmd_take)
            c_reg <= cmd;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_q <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/text_console_writer_unit.sv -----
// Top level of the text console writer: APB color registers, front decoder
// and back executor. Depends on tcw_pkg, tcw_front, tcw_back.
//
//  channel   direction  handshake          payload
//  request   in         push / full        req_item  (tcw_pkg::in_item_t)
//  result    out        pop / empty        res_item  (tcw_pkg::out_item_t)
//  config    in         APB psel/penable   back_color @0, fore_color @4
//
// Set cursor, CR and print pass EXEC then DONE, plus result wait; read and BS
// add a read state between. Scroll walks one row of SCREEN_WIDTH cells;
// clear walks 2000 cells. After reset all 2000 cells are cleared to zero;
// requests queue meanwhile; full rises once the two-entry queue holds two.
// A two-entry command queue lets requests be taken while the back end is busy.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire tcw_pkg::in_item_t req_item,
    output logic              empty,
    input  wire logic         pop,
    output tcw_pkg::out_item_t res_item,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tcw_pkg::*;

    logic [3:0] back_reg, fore_reg;
    logic cmd_valid, cmd_take, res_valid;
    cmd_t cmd;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_reg <= 4'd0;
            fore_reg <= 4'd7;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_BACK)
                back_reg <= pwdata[3:0];
            else if (paddr == ADDR_FORE)
                fore_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_BACK: prdata = {28'd0, back_reg};
            ADDR_FORE: prdata = {28'd0, fore_reg};
            default:   prdata = '0;
        endcase
    end

    tcw_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(req_item),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    tcw_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .back_color(back_reg), .fore_color(fore_reg),
        .res_valid(res_valid), .res(res_item), .res_take(pop)
    );

    assign empty = !res_valid;
endmodule
`default_nettype wire
